// ===== design/sorted_record_table_macros.svh =====
// Assertion macros for the sorted record table.
`ifndef SORTED_RECORD_TABLE_MACROS_SVH
`define SORTED_RECORD_TABLE_MACROS_SVH

`ifndef ASSERT_OFF

// check on every clock edge outside reset
`define SRT_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("sorted_record_table assertion failed");

// check on every clock edge, reset included
`define SRT_ASSERT_ALWAYS(label, prop) \
   label: assert property (@(posedge clock) prop) \
      else $error("sorted_record_table assertion failed");

`else

`define SRT_ASSERT(label, prop)
`define SRT_ASSERT_ALWAYS(label, prop)

`endif

`endif

// ===== design/srt_pkg.sv =====
`default_nettype none

package srt_pkg;

   localparam int CAPACITY_DEFAULT = 32;
   localparam int KEY_W            = 32;
   localparam int SCORE_W          = 32;
   localparam int REMOVED_W        = 6;

   typedef enum logic [1:0] {
      ACT_INSERT = 2'd0,
      ACT_DELETE = 2'd1,
      ACT_LIST   = 2'd2,
      ACT_CLEAR  = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INS_SCAN,
      ST_INS_LAST,
      ST_DEL_SCAN,
      ST_LIST_LOAD,
      ST_RESP
   } state_type;

endpackage

`default_nettype wire

// ===== design/srt_ram.sv =====
`default_nettype none

module srt_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== design/sorted_record_table.sv =====
// Sorted record table: holds up to CAPACITY records (signed key, signed score) in
// ascending key order in one RAM, walked by a small sequencer one entry per cycle
// during the insert and delete scans. One request is taken at a time; req_stall is
// high from acceptance until the last response of that request has been taken.
// Insert shifts entries up from the top down until the slot is found, delete makes
// one compaction pass, and clear, a full-table insert and an empty-table insert go
// straight to their single response. List returns one response per stored record,
// each a RAM read and then a load of the response register, rsp_last on the final
// one; an empty list gives one response with rsp_entry_valid low. The RAM has
// registered read data. No clearing pass: reset empties the table at once.
`default_nettype none
`include "sorted_record_table_macros.svh"

module sorted_record_table #(
   parameter int CAPACITY = srt_pkg::CAPACITY_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [1:0]                          req_action,
   input  wire logic signed [srt_pkg::KEY_W-1:0]    req_key,
   input  wire logic signed [srt_pkg::SCORE_W-1:0]  req_score,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic signed [srt_pkg::KEY_W-1:0]         rsp_out_key,
   output logic signed [srt_pkg::SCORE_W-1:0]       rsp_out_score,
   output logic                                     rsp_entry_valid,
   output logic [srt_pkg::REMOVED_W-1:0]            rsp_removed_count,
   output logic                                     rsp_status,
   output logic                                     rsp_last
);

   localparam int IDX_W  = $clog2(CAPACITY);
   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int DATA_W = srt_pkg::KEY_W + srt_pkg::SCORE_W;

   srt_pkg::state_type  state_ff, state_in;
   srt_pkg::action_type action_ff, action_in;

   logic [CNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] wptr_ff, wptr_in;

   logic signed [srt_pkg::KEY_W-1:0]   key_ff, key_in;
   logic signed [srt_pkg::SCORE_W-1:0] score_ff, score_in;

   logic signed [srt_pkg::KEY_W-1:0]   rsp_key_ff, rsp_key_in;
   logic signed [srt_pkg::SCORE_W-1:0] rsp_score_ff, rsp_score_in;
   logic                               rsp_entry_ff, rsp_entry_in;
   logic [srt_pkg::REMOVED_W-1:0]      rsp_removed_ff, rsp_removed_in;
   logic                               rsp_status_ff, rsp_status_in;
   logic                               rsp_last_ff, rsp_last_in;

   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   logic [DATA_W-1:0] wr_data;
   logic [IDX_W-1:0]  rd_addr;
   logic [DATA_W-1:0] rd_data;

   logic signed [srt_pkg::KEY_W-1:0] rd_key;
   logic                             req_take;
   logic                             rsp_take;
   logic                             table_full;
   logic                             table_empty;
   logic                             idx_last;
   logic                             rd_less;

   srt_ram #(
      .WIDTH (DATA_W),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_key      = $signed(rd_data[DATA_W-1:srt_pkg::SCORE_W]);
   assign req_stall   = (state_ff != srt_pkg::ST_IDLE);
   assign req_take    = req_valid && !req_stall;
   assign rsp_valid   = (state_ff == srt_pkg::ST_RESP);
   assign rsp_take    = rsp_valid && !rsp_stall;
   assign table_full  = (count_ff == CNT_W'(CAPACITY));
   assign table_empty = (count_ff == '0);
   assign idx_last    = ((CNT_W'(idx_ff) + CNT_W'(1)) == count_ff);
   assign rd_less     = (rd_key < key_ff);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         srt_pkg::ST_IDLE: begin
            if (req_take) begin
               unique case (srt_pkg::action_type'(req_action))
                  srt_pkg::ACT_INSERT: begin
                     state_in = (table_full || table_empty) ? srt_pkg::ST_RESP
                                                            : srt_pkg::ST_INS_SCAN;
                  end
                  srt_pkg::ACT_DELETE: begin
                     state_in = table_empty ? srt_pkg::ST_RESP : srt_pkg::ST_DEL_SCAN;
                  end
                  srt_pkg::ACT_LIST: begin
                     state_in = table_empty ? srt_pkg::ST_RESP : srt_pkg::ST_LIST_LOAD;
                  end
                  srt_pkg::ACT_CLEAR: begin
                     state_in = srt_pkg::ST_RESP;
                  end
               endcase
            end
         end
         srt_pkg::ST_INS_SCAN: begin
            priority if (rd_less) begin
               state_in = srt_pkg::ST_RESP;
            end else if (idx_ff == '0) begin
               state_in = srt_pkg::ST_INS_LAST;
            end else begin
               state_in = srt_pkg::ST_INS_SCAN;
            end
         end
         srt_pkg::ST_INS_LAST: begin
            state_in = srt_pkg::ST_RESP;
         end
         srt_pkg::ST_DEL_SCAN: begin
            if (idx_last) begin
               state_in = srt_pkg::ST_RESP;
            end
         end
         srt_pkg::ST_LIST_LOAD: begin
            state_in = srt_pkg::ST_RESP;
         end
         srt_pkg::ST_RESP: begin
            if (rsp_take) begin
               state_in = (action_ff == srt_pkg::ACT_LIST && !rsp_last_ff)
                          ? srt_pkg::ST_LIST_LOAD : srt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = srt_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      logic [CNT_W-1:0] wptr_next;
      wptr_next      = wptr_ff;
      action_in      = action_ff;
      count_in       = count_ff;
      idx_in         = idx_ff;
      wptr_in        = wptr_ff;
      key_in         = key_ff;
      score_in       = score_ff;
      rsp_key_in     = rsp_key_ff;
      rsp_score_in   = rsp_score_ff;
      rsp_entry_in   = rsp_entry_ff;
      rsp_removed_in = rsp_removed_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_last_in    = rsp_last_ff;
      wr_en          = 1'b0;
      wr_addr        = '0;
      wr_data        = '0;
      rd_addr        = '0;
      unique case (state_ff)
         srt_pkg::ST_IDLE: begin
            if (req_take) begin
               action_in      = srt_pkg::action_type'(req_action);
               key_in         = req_key;
               score_in       = req_score;
               rsp_key_in     = '0;
               rsp_score_in   = '0;
               rsp_entry_in   = 1'b0;
               rsp_removed_in = '0;
               rsp_status_in  = 1'b0;
               rsp_last_in    = 1'b1;
               idx_in         = '0;
               wptr_in        = '0;
               unique case (srt_pkg::action_type'(req_action))
                  srt_pkg::ACT_INSERT: begin
                     priority if (table_full) begin
                        rsp_status_in = 1'b1;
                     end else if (table_empty) begin
                        wr_en    = 1'b1;
                        wr_data  = {req_key, req_score};
                        count_in = count_ff + CNT_W'(1);
                     end else begin
                        rd_addr = IDX_W'(count_ff - CNT_W'(1));
                        idx_in  = IDX_W'(count_ff - CNT_W'(1));
                     end
                  end
                  srt_pkg::ACT_DELETE: begin
                     rd_addr = '0;
                  end
                  srt_pkg::ACT_LIST: begin
                     rd_addr = '0;
                  end
                  srt_pkg::ACT_CLEAR: begin
                     count_in = '0;
                  end
               endcase
            end
         end
         srt_pkg::ST_INS_SCAN: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff + IDX_W'(1);
            if (rd_less) begin
               wr_data  = {key_ff, score_ff};
               count_in = count_ff + CNT_W'(1);
            end else begin
               wr_data = rd_data;
               idx_in  = idx_ff - IDX_W'(1);
               rd_addr = idx_ff - IDX_W'(1);
            end
         end
         srt_pkg::ST_INS_LAST: begin
            wr_en    = 1'b1;
            wr_addr  = '0;
            wr_data  = {key_ff, score_ff};
            count_in = count_ff + CNT_W'(1);
         end
         srt_pkg::ST_DEL_SCAN: begin
            if (rd_key != key_ff) begin
               wr_en     = 1'b1;
               wr_addr   = wptr_ff[IDX_W-1:0];
               wr_data   = rd_data;
               wptr_next = wptr_ff + CNT_W'(1);
            end
            wptr_in = wptr_next;
            if (idx_last) begin
               count_in       = wptr_next;
               rsp_removed_in = srt_pkg::REMOVED_W'(count_ff - wptr_next);
            end else begin
               idx_in  = idx_ff + IDX_W'(1);
               rd_addr = idx_ff + IDX_W'(1);
            end
         end
         srt_pkg::ST_LIST_LOAD: begin
            rsp_key_in   = rd_key;
            rsp_score_in = $signed(rd_data[srt_pkg::SCORE_W-1:0]);
            rsp_entry_in = 1'b1;
            rsp_last_in  = idx_last;
         end
         srt_pkg::ST_RESP: begin
            rd_addr = idx_ff + IDX_W'(1);
            if (rsp_take && action_ff == srt_pkg::ACT_LIST && !rsp_last_ff) begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= srt_pkg::ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff      <= action_in;
      idx_ff         <= idx_in;
      wptr_ff        <= wptr_in;
      key_ff         <= key_in;
      score_ff       <= score_in;
      rsp_key_ff     <= rsp_key_in;
      rsp_score_ff   <= rsp_score_in;
      rsp_entry_ff   <= rsp_entry_in;
      rsp_removed_ff <= rsp_removed_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_out_key       = rsp_key_ff;
   assign rsp_out_score     = rsp_score_ff;
   assign rsp_entry_valid   = rsp_entry_ff;
   assign rsp_removed_count = rsp_removed_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_last          = rsp_last_ff;

   `SRT_ASSERT_ALWAYS(a_count_bound, reset || count_ff <= CNT_W'(CAPACITY))
   `SRT_ASSERT(a_entry_only_list,
      (rsp_valid && rsp_entry_ff) |-> (action_ff == srt_pkg::ACT_LIST))
   `SRT_ASSERT(a_resp_exit, (rsp_valid && !rsp_stall) |=>
      (state_ff == srt_pkg::ST_IDLE || state_ff == srt_pkg::ST_LIST_LOAD))
   `SRT_ASSERT(a_write_states, wr_en |->
      (state_ff == srt_pkg::ST_IDLE || state_ff == srt_pkg::ST_INS_SCAN ||
       state_ff == srt_pkg::ST_INS_LAST || state_ff == srt_pkg::ST_DEL_SCAN))
   `SRT_ASSERT(a_full_insert_holds,
      (req_take && req_action == srt_pkg::ACT_INSERT && table_full) |=>
      (count_ff == $past(count_ff)))

endmodule

`default_nettype wire

// ===== tb/sv/sorted_record_table_test.sv =====
module sorted_record_table_test;

   localparam int CAPACITY        = srt_pkg::CAPACITY_DEFAULT;
   localparam int KEY_W           = srt_pkg::KEY_W;
   localparam int SCORE_W         = srt_pkg::SCORE_W;
   localparam int REMOVED_W       = srt_pkg::REMOVED_W;
   localparam int RANDOM_REQUESTS = 360;
   localparam int CYCLE_LIMIT     = 1000000;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int DRAIN_CYCLES    = 40;

   localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh80000000;
   localparam logic signed [KEY_W-1:0] KEY_MAX = 32'sh7fffffff;

   typedef struct packed {
      logic [KEY_W-1:0]     out_key;
      logic [SCORE_W-1:0]   out_score;
      logic                 entry_valid;
      logic [REMOVED_W-1:0] removed_count;
      logic                 status;
      logic                 last;
   } table_response_type;

   class table_tracker;
      logic signed [KEY_W-1:0]   keys [CAPACITY];
      logic signed [SCORE_W-1:0] scores [CAPACITY];
      int                        count;
      int                        errors;
      table_response_type        awaited_responses [$];

      function new();
         count = 0;
         errors = 0;
      endfunction

      function void note_request(srt_pkg::action_type act, logic signed [KEY_W-1:0] key,
                                 logic signed [SCORE_W-1:0] score);
         table_response_type r;
         int pos;
         int kept;
         int i;
         r = '0;
         r.last = 1'b1;
         case (act)
            srt_pkg::ACT_INSERT: begin
               if (count >= CAPACITY) begin
                  r.status = 1'b1;
               end else begin
                  pos = 0;
                  while (pos < count && keys[pos] < key) pos++;
                  for (i = count; i > pos; i--) begin
                     keys[i] = keys[i-1];
                     scores[i] = scores[i-1];
                  end
                  keys[pos] = key;
                  scores[pos] = score;
                  count++;
               end
               awaited_responses.push_back(r);
            end
            srt_pkg::ACT_DELETE: begin
               kept = 0;
               for (i = 0; i < count; i++) begin
                  if (keys[i] != key) begin
                     keys[kept] = keys[i];
                     scores[kept] = scores[i];
                     kept++;
                  end
               end
               r.removed_count = REMOVED_W'(count - kept);
               count = kept;
               awaited_responses.push_back(r);
            end
            srt_pkg::ACT_LIST: begin
               if (count == 0) begin
                  awaited_responses.push_back(r);
               end else begin
                  for (i = 0; i < count; i++) begin
                     r.out_key = keys[i];
                     r.out_score = scores[i];
                     r.entry_valid = 1'b1;
                     r.last = (i == count - 1);
                     awaited_responses.push_back(r);
                  end
               end
            end
            default: begin
               count = 0;
               awaited_responses.push_back(r);
            end
         endcase
      endfunction

      function void check_response(table_response_type got);
         table_response_type want;
         if (awaited_responses.size() == 0) begin
            $error("response with no request waiting: out_key %0d", $signed(got.out_key));
            errors++;
            return;
         end
         want = awaited_responses.pop_front();
         if (got.out_key !== want.out_key) begin
            $error("out_key: expected %0d, actual %0d",
                   $signed(want.out_key), $signed(got.out_key));
            errors++;
         end
         if (got.out_score !== want.out_score) begin
            $error("out_score: expected %0d, actual %0d",
                   $signed(want.out_score), $signed(got.out_score));
            errors++;
         end
         if (got.entry_valid !== want.entry_valid) begin
            $error("entry_valid: expected %0d, actual %0d", want.entry_valid, got.entry_valid);
            errors++;
         end
         if (got.removed_count !== want.removed_count) begin
            $error("removed_count: expected %0d, actual %0d",
                   want.removed_count, got.removed_count);
            errors++;
         end
         if (got.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            errors++;
         end
         if (got.last !== want.last) begin
            $error("last: expected %0d, actual %0d", want.last, got.last);
            errors++;
         end
      endfunction

      function int pending();
         return awaited_responses.size();
      endfunction
   endclass

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic [1:0]                 req_action = '0;
   logic signed [KEY_W-1:0]    req_key = '0;
   logic signed [SCORE_W-1:0]  req_score = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic signed [KEY_W-1:0]    rsp_out_key;
   logic signed [SCORE_W-1:0]  rsp_out_score;
   logic                       rsp_entry_valid;
   logic [REMOVED_W-1:0]       rsp_removed_count;
   logic                       rsp_status;
   logic                       rsp_last;

   table_tracker tracker;
   int           send_gap_max = 7;
   bit           hold_off_request = 1'b0;
   bit           rsp_quiet = 1'b0;
   int unsigned  cycle_count = 0;

   sorted_record_table #(.CAPACITY(CAPACITY)) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_action        (req_action),
      .req_key           (req_key),
      .req_score         (req_score),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_key       (rsp_out_key),
      .rsp_out_score     (rsp_out_score),
      .rsp_entry_valid   (rsp_entry_valid),
      .rsp_removed_count (rsp_removed_count),
      .rsp_status        (rsp_status),
      .rsp_last          (rsp_last)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("sorted_record_table test failed");
         $finish;
      end
   end

   task automatic send_request(srt_pkg::action_type act, logic signed [KEY_W-1:0] key,
                               logic signed [SCORE_W-1:0] score);
      int gap;
      gap = $urandom_range(0, send_gap_max);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_key <= key;
      req_score <= score;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      tracker.note_request(act, key, score);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (tracker.pending() != 0) @(posedge clock);
   endtask

   function automatic logic signed [KEY_W-1:0] pick_key();
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return $urandom_range(0, 8) - 4;
         2: begin
            case ($urandom_range(0, 3))
               0: return KEY_MIN;
               1: return KEY_MAX;
               2: return 0;
               default: return -1;
            endcase
         end
         default: begin
            if (tracker.count > 0) return tracker.keys[$urandom_range(0, tracker.count - 1)];
            return $urandom;
         end
      endcase
   endfunction

   function automatic logic signed [SCORE_W-1:0] pick_score();
      case ($urandom_range(0, 7))
         0: return KEY_MIN;
         1: return KEY_MAX;
         default: return $urandom;
      endcase
   endfunction

   initial begin
      table_response_type got;
      int hold;
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            hold = HOLD_OFF_CYCLES;
         end else if (rsp_quiet) begin
            hold = 0;
         end else begin
            hold = $urandom_range(0, 7);
         end
         if ($urandom_range(0, 59) == 0) rsp_quiet = !rsp_quiet;
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         got.out_key = rsp_out_key;
         got.out_score = rsp_out_score;
         got.entry_valid = rsp_entry_valid;
         got.removed_count = rsp_removed_count;
         got.status = rsp_status;
         got.last = rsp_last;
         tracker.check_response(got);
      end
   end

   initial begin
      int issued;
      int kind;
      int burst;
      int fill;
      int pick;
      bit held;
      bit paused;
      tracker = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      send_request(srt_pkg::ACT_LIST, 0, 0);
      send_request(srt_pkg::ACT_DELETE, 5, 0);
      send_request(srt_pkg::ACT_CLEAR, 0, 0);
      send_request(srt_pkg::ACT_INSERT, KEY_MAX, KEY_MIN);
      send_request(srt_pkg::ACT_INSERT, KEY_MIN, KEY_MAX);
      send_request(srt_pkg::ACT_INSERT, 0, -1);
      send_request(srt_pkg::ACT_INSERT, -1, 0);
      send_request(srt_pkg::ACT_INSERT, 7, 1);
      send_request(srt_pkg::ACT_INSERT, 7, 2);
      send_request(srt_pkg::ACT_INSERT, 7, 3);
      send_request(srt_pkg::ACT_LIST, 0, 0);
      send_request(srt_pkg::ACT_DELETE, 7, 0);
      send_request(srt_pkg::ACT_DELETE, 7, 0);
      send_request(srt_pkg::ACT_INSERT, KEY_MIN, 5);
      send_request(srt_pkg::ACT_INSERT, KEY_MAX, 6);
      send_request(srt_pkg::ACT_LIST, 0, 0);
      send_request(srt_pkg::ACT_DELETE, KEY_MIN, 0);
      send_request(srt_pkg::ACT_CLEAR, 0, 0);
      send_request(srt_pkg::ACT_LIST, 0, 0);
      wait_drained();

      issued = 0;
      held = 1'b0;
      paused = 1'b0;
      while (issued < RANDOM_REQUESTS) begin
         send_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 7;
         if (!held && issued >= 100) begin
            held = 1'b1;
            hold_off_request = 1'b1;
         end
         if (!paused && issued >= 220) begin
            paused = 1'b1;
            wait_drained();
         end
         kind = $urandom_range(0, 4);
         if (kind == 0) begin
            // fill past capacity, then read back
            fill = CAPACITY - tracker.count + $urandom_range(1, 3);
            repeat (fill) begin
               send_request(srt_pkg::ACT_INSERT, pick_key(), pick_score());
               issued++;
            end
            send_request(srt_pkg::ACT_LIST, pick_key(), pick_score());
            issued++;
         end else begin
            burst = $urandom_range(5, 20);
            repeat (burst) begin
               pick = $urandom_range(0, 19);
               if (pick < 10) send_request(srt_pkg::ACT_INSERT, pick_key(), pick_score());
               else if (pick < 15) send_request(srt_pkg::ACT_DELETE, pick_key(), pick_score());
               else if (pick < 18) send_request(srt_pkg::ACT_LIST, pick_key(), pick_score());
               else send_request(srt_pkg::ACT_CLEAR, pick_key(), pick_score());
               issued++;
            end
         end
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (tracker.errors == 0 && tracker.pending() == 0) begin
         $display("sorted_record_table test passed");
      end else begin
         $display("sorted_record_table test failed");
      end
      $finish;
   end

endmodule
